### src/rsd_pkg.sv
// Package for the radar sweep deframer: constants, types and helper functions.
// No dependencies.
package rsd_pkg;

    localparam int MAX_SAMPLE_BITS  = 24;
    localparam int MAX_SWEEP_LENGTH = 65536;

    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam logic [7:0] STOP_BYTE  = 8'h8F;

    localparam int SAMPLE_W = 25;
    localparam int INDEX_W  = 16;
    localparam int CFG_W    = 17;

    typedef enum logic [1:0] {
        EV_SAMPLE = 2'd0,
        EV_FINAL  = 2'd1,
        EV_ABORT  = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        REG_SAMPLE_BITS  = 2'd0,
        REG_SWEEP_LENGTH = 2'd1,
        REG_FFT_MODE     = 2'd2
    } t_reg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;        // clear word and byte position
        logic load_byte;    // merge byte into the word
        logic start_mag;    // begin magnitude computation
        logic emit;         // present a result
        t_event kind;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_byte;    // the byte being loaded completes a sample
        logic last_sample;  // the sample being completed is the last of the sweep
        logic mag_done;
        logic out_free;     // output register can take a result
    } t_status;

endpackage

### src/rsd_stream_if.sv
// Valid/ready stream interface carrying a parametric payload.
// Depends on nothing.
interface rsd_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/rsd_sqrt.sv
// Iterative rounded integer square root, one result bit per cycle.
// Depends on nothing.
module rsd_sqrt #(
    parameter int IN_W = 50,
    parameter int OUT_W = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [IN_W-1:0]  i_value,
    output logic             o_done,
    output logic [OUT_W-1:0] o_root
);
    localparam int HW  = (IN_W + 1) / 2;
    localparam int CW  = $clog2(HW + 1);
    localparam int RW  = HW + 2;

    logic [2*HW-1:0] r_num;
    logic [RW-1:0]   r_rem;
    logic [HW-1:0]   r_root;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [RW-1:0] n_trial_rem;
    logic [RW-1:0] n_trial;

    always_comb begin
        n_trial_rem = {r_rem[RW-3:0], r_num[2*HW-1 -: 2]};
        n_trial     = {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= (2*HW)'(i_value);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CW'(HW);
            end else if (r_busy) begin
                r_num <= r_num << 2;
                if (n_trial_rem >= n_trial) begin
                    r_rem  <= n_trial_rem - n_trial;
                    r_root <= {r_root[HW-2:0], 1'b1};
                end else begin
                    r_rem  <= n_trial_rem;
                    r_root <= {r_root[HW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Round up when the remainder exceeds the root.
    logic [RW-1:0] n_root_ext;
    assign n_root_ext = RW'(r_root);
    assign o_done = r_done;
    assign o_root = (r_rem > n_root_ext) ? OUT_W'(r_root) + OUT_W'(1) : OUT_W'(r_root);
endmodule

### src/rsd_datapath.sv
// Datapath: byte assembly, sample extraction, magnitude and output register.
// Depends on rsd_pkg and rsd_sqrt.
module rsd_datapath #(
    parameter int MAX_BITS = rsd_pkg::MAX_SAMPLE_BITS,
    parameter int MAX_LEN  = rsd_pkg::MAX_SWEEP_LENGTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [7:0]                  i_byte,
    input  logic [4:0]                  i_sample_bits,
    input  logic [16:0]                 i_sweep_length,
    input  logic                        i_fft_mode,
    input  rsd_pkg::t_cmd               i_cmd,
    output rsd_pkg::t_status            o_status,
    output logic [$clog2(MAX_BITS*2/8+2):0] o_flags_needed,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [rsd_pkg::SAMPLE_W+rsd_pkg::INDEX_W+1:0] o_out_data
);
    import rsd_pkg::*;

    localparam int WORD_W = 64;
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int SQ_W   = 2 * MAX_BITS + 1;
    localparam int FN_W   = $clog2(MAX_BITS*2/8+2) + 1;

    logic [4:0]  n_bits;
    logic [5:0]  n_wbits;
    logic [3:0]  n_bps;
    logic [LEN_W-1:0] n_len;

    always_comb begin
        logic [3:0] q;
        logic [3:0] c;
        n_bits = i_sample_bits;
        if (n_bits < 5'd2) n_bits = 5'd2;
        if (32'(n_bits) > MAX_BITS) n_bits = 5'(MAX_BITS);
        n_wbits = i_fft_mode ? {n_bits, 1'b0} : {1'b0, n_bits};
        c = 4'((n_wbits + 6'd7) >> 3);
        q = 4'(n_wbits >> 3) + 4'd1;
        n_bps = (c <= 4'd1) ? 4'd1 : (c <= 4'd2) ? 4'd2 : (c <= 4'd4) ? 4'd4 : 4'd8;
        o_flags_needed = (q <= 4'd1) ? FN_W'(1) : (q <= 4'd2) ? FN_W'(2) :
                         (q <= 4'd4) ? FN_W'(4) : FN_W'(8);
        if (i_sweep_length == 17'd0) n_len = LEN_W'(1);
        else if (32'(i_sweep_length) > MAX_LEN) n_len = LEN_W'(MAX_LEN);
        else n_len = LEN_W'(i_sweep_length);
    end

    logic [WORD_W-1:0] r_word;
    logic [2:0]        r_pos;
    logic [LEN_W-1:0]  r_sweep;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        logic [3:0] sh;
        sh = (4'(r_pos) < n_bps) ? (n_bps - 4'd1 - 4'(r_pos)) : 4'd0;
        n_word = r_word | (WORD_W'(i_byte) << {sh, 3'b000});
    end

    assign o_status.last_byte   = (4'(r_pos) + 4'd1) >= n_bps;
    assign o_status.last_sample = (r_sweep + LEN_W'(1)) >= n_len;

    // Component extraction from the completed word.
    logic signed [MAX_BITS-1:0] n_a;
    logic signed [MAX_BITS-1:0] n_b;
    always_comb begin
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        lo = n_word << (WORD_W - 32'(n_bits));
        hi = (n_word >> n_bits) << (WORD_W - 32'(n_bits));
        n_a = MAX_BITS'($signed(lo) >>> (WORD_W - 32'(n_bits)));
        n_b = MAX_BITS'($signed(hi) >>> (WORD_W - 32'(n_bits)));
    end

    // Registered components and squares, two steps before the root unit.
    logic [MAX_BITS-1:0]   r_ua;
    logic [MAX_BITS-1:0]   r_ub;
    logic [SQ_W-1:0]       r_sum;
    logic                  r_sq_go;
    logic                  r_rt_go;
    logic                  mag_done;
    logic [SAMPLE_W-1:0]   mag_root;
    logic [SAMPLE_W-1:0]   r_value;
    logic [INDEX_W-1:0]    r_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_go <= 1'b0;
            r_rt_go <= 1'b0;
        end else begin
            r_sq_go <= i_cmd.start_mag;
            r_rt_go <= r_sq_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_mag) begin
            r_ua <= n_a[MAX_BITS-1] ? MAX_BITS'(-n_a) : MAX_BITS'(n_a);
            r_ub <= n_b[MAX_BITS-1] ? MAX_BITS'(-n_b) : MAX_BITS'(n_b);
        end
        if (r_sq_go) r_sum <= SQ_W'(r_ua) * SQ_W'(r_ua) + SQ_W'(r_ub) * SQ_W'(r_ub);
    end

    rsd_sqrt #(.IN_W(SQ_W), .OUT_W(SAMPLE_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_rt_go),
        .i_value (r_sum),
        .o_done  (mag_done),
        .o_root  (mag_root)
    );
    assign o_status.mag_done = mag_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_word  <= '0;
            r_sweep <= '0;
        end else if (i_cmd.clear) begin
            r_pos   <= '0;
            r_word  <= '0;
            r_sweep <= '0;
        end else if (i_cmd.load_byte) begin
            if (o_status.last_byte) begin
                r_pos   <= '0;
                r_word  <= '0;
                r_sweep <= r_sweep + LEN_W'(1);
                r_index <= INDEX_W'(r_sweep);
                if (!i_fft_mode) r_value <= SAMPLE_W'(n_a);
            end else begin
                r_pos  <= r_pos + 3'd1;
                r_word <= n_word;
            end
        end
        if (mag_done) r_value <= mag_root;
    end

    // Output register.
    logic                              r_ovalid;
    logic [SAMPLE_W+INDEX_W+1:0]       r_odata;
    assign o_status.out_free = !r_ovalid || i_out_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
                r_odata  <= (i_cmd.kind == EV_ABORT) ?
                            {EV_ABORT, {SAMPLE_W{1'b0}}, {INDEX_W{1'b0}}} :
                            {i_cmd.kind, r_value, r_index};
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
endmodule

### src/rsd_ctrl.sv
// Controller state machine: framing phases and sequencing of the datapath.
// Depends on rsd_pkg.
module rsd_ctrl #(
    parameter int FN_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_fft_mode,
    input  logic [FN_W-1:0]   i_flags_needed,
    input  rsd_pkg::t_status  i_status,
    output rsd_pkg::t_cmd     o_cmd
);
    import rsd_pkg::*;

    typedef enum logic [5:0] {
        S_HUNT  = 6'b000001,
        S_SAMP  = 6'b000010,
        S_MAG   = 6'b000100,
        S_EMIT  = 6'b001000,
        S_STOP  = 6'b010000,
        S_FINAL = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [FN_W-1:0]   r_run, n_run;
    logic              r_last, n_last;
    logic              acc;

    always_comb begin
        n_state = r_state;
        n_run   = r_run;
        n_last  = r_last;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.kind = EV_SAMPLE;
        acc = 1'b0;
        unique case (r_state)
            S_HUNT: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_run = (i_byte == START_BYTE) ? r_run + FN_W'(1) : '0;
                    if (n_run >= i_flags_needed) begin
                        n_run = '0;
                        o_cmd.clear = 1'b1;
                        n_state = S_SAMP;
                    end
                end
            end
            S_SAMP: begin
                o_ready = 1'b1;
                acc = i_valid;
                if (acc) begin
                    o_cmd.load_byte = 1'b1;
                    if (i_status.last_byte) begin
                        n_last = i_status.last_sample;
                        o_cmd.start_mag = i_fft_mode;
                        if (i_fft_mode) n_state = S_MAG;
                        else n_state = i_status.last_sample ? S_STOP : S_EMIT;
                        n_run = '0;
                    end
                end
            end
            S_MAG: begin
                if (i_status.mag_done) n_state = r_last ? S_STOP : S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_SAMP;
                end
            end
            S_STOP: begin
                o_ready = i_status.out_free;
                if (i_valid && o_ready) begin
                    if (i_byte == STOP_BYTE) begin
                        n_run = r_run + FN_W'(1);
                        if (n_run >= i_flags_needed) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.kind = EV_FINAL;
                            n_state = S_FINAL;
                        end
                    end else begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = EV_ABORT;
                        n_state = S_FINAL;
                    end
                end
            end
            S_FINAL: begin
                o_cmd.clear = 1'b1;
                n_run = '0;
                n_state = S_HUNT;
            end
            default: n_state = S_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
            r_run   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
            r_last  <= n_last;
        end
    end
endmodule

### src/radar_sweep_deframer_unit.sv
// Top level of the radar sweep deframer: configuration registers and wiring.
// Depends on rsd_pkg, rsd_stream_if, rsd_ctrl and rsd_datapath.
//
// The deframer takes one received byte per request on the input stream, finds
// a run of 0xFF start bytes, assembles each sweep's big-endian samples and
// confirms the sweep with a run of 0x8F stop bytes. Start, sample and stop
// bytes are taken one per cycle save where the block waits, as below. In plain
// mode each finished sample but the last of a sweep passes an emit state that
// moves it to the output register. In fft mode the magnitude goes through a
// square and sum stage and then an iterative square root that retires one
// result bit a cycle; no byte is taken meanwhile, so that root unit sets the
// rate. The end of a sweep, confirmed or aborted, passes a final state that
// clears the datapath before hunting resumes. Results wait in an output
// register; stop bytes are taken only when it is free, and a sample waits for
// it before the next byte is taken. The user must write the configuration
// via the plain write port only while the block idles, which is not enforced.
module radar_sweep_deframer_unit #(
    parameter int MAX_SAMPLE_BITS  = rsd_pkg::MAX_SAMPLE_BITS,
    parameter int MAX_SWEEP_LENGTH = rsd_pkg::MAX_SWEEP_LENGTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [rsd_pkg::CFG_W-1:0] i_cfg_data,
    rsd_stream_if.sink          in_s,
    rsd_stream_if.source        out_s
);
    import rsd_pkg::*;

    localparam int FN_W = $clog2(MAX_SAMPLE_BITS*2/8+2) + 1;

    logic [4:0]  r_sample_bits;
    logic [16:0] r_sweep_length;
    logic        r_fft_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_bits  <= 5'd12;
            r_sweep_length <= 17'd20480;
            r_fft_mode     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_index))
                REG_SAMPLE_BITS:  r_sample_bits  <= i_cfg_data[4:0];
                REG_SWEEP_LENGTH: r_sweep_length <= i_cfg_data[16:0];
                REG_FFT_MODE:     r_fft_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    t_cmd             cmd;
    t_status          status;
    logic [FN_W-1:0]  flags_needed;

    rsd_ctrl #(.FN_W(FN_W)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_s.valid),
        .o_ready        (in_s.ready),
        .i_byte         (in_s.data),
        .i_fft_mode     (r_fft_mode),
        .i_flags_needed (flags_needed),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    rsd_datapath #(.MAX_BITS(MAX_SAMPLE_BITS), .MAX_LEN(MAX_SWEEP_LENGTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte         (in_s.data),
        .i_sample_bits  (r_sample_bits),
        .i_sweep_length (r_sweep_length),
        .i_fft_mode     (r_fft_mode),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_flags_needed (flags_needed),
        .i_out_ready    (out_s.ready),
        .o_out_valid    (out_s.valid),
        .o_out_data     (out_s.data)
    );
endmodule

### src/rsd_checker.sv
// Port-level checker for the radar sweep deframer, bound to the top level.
// Depends on rsd_pkg and rsd_stream_if.
module rsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [42:0] out_data
);
    import rsd_pkg::*;

    // An offered request stays offered until it is taken.
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("request withdrawn before it was taken");

    // A waiting result holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Event codes stay within the defined set.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data[42:41] != 2'd3)
        else $error("bad event code");

    // An abort carries zero value and index.
    a_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data[42:41] == EV_ABORT |-> out_data[40:0] == '0)
        else $error("abort with payload");

    // Nothing is shown just after reset.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("result after reset");
endmodule

bind radar_sweep_deframer_unit rsd_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_s.valid),
    .in_ready  (in_s.ready),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .out_data  (out_s.data)
);

### dv/tb.sv
// Self-checking testbench for radar_sweep_deframer_unit: framed byte streams in,
// sample, final and abort events checked against an in-bench predictor.
// Depends on rsd_pkg, rsd_stream_if and the deframer RTL.
`timescale 1ns / 1ps

module tb;
    import rsd_pkg::*;

    localparam int OUT_W = 2 + SAMPLE_W + INDEX_W;

    typedef struct {
        t_event                      kind;
        logic signed [SAMPLE_W-1:0]  value;
        logic        [INDEX_W-1:0]   index;
    } t_sweep_event;

    typedef enum logic [1:0] {
        HUNT    = 2'd0,
        SAMPLES = 2'd1,
        STOPS   = 2'd2
    } t_track;

    // Scoreboard: tracks the deframer state and holds the events still due.
    class sweep_scoreboard;
        logic [4:0]   bits_reg;
        logic [16:0]  length_reg;
        logic         fft_reg;
        t_track       track;
        int unsigned  flag_count;
        int unsigned  byte_pos;
        logic [63:0]  word;
        int unsigned  sweep_pos;
        logic signed [SAMPLE_W-1:0] held_value;
        t_sweep_event due[$];
        int unsigned  mismatches;

        function void reset_state();
            bits_reg = 5'd12;
            length_reg = 17'd20480;
            fft_reg = 1'b0;
            track = HUNT;
            flag_count = 0;
            byte_pos = 0;
            word = '0;
            sweep_pos = 0;
            held_value = '0;
            due.delete();
            mismatches = 0;
        endfunction

        function void write_reg(t_reg idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_SAMPLE_BITS:  bits_reg = val[4:0];
                REG_SWEEP_LENGTH: length_reg = val[16:0];
                REG_FFT_MODE:     fft_reg = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned comp_bits();
            if (bits_reg < 2) return 2;
            if (bits_reg > MAX_SAMPLE_BITS) return MAX_SAMPLE_BITS;
            return bits_reg;
        endfunction

        function int unsigned sample_count();
            if (length_reg < 1) return 1;
            if (length_reg > MAX_SWEEP_LENGTH) return MAX_SWEEP_LENGTH;
            return length_reg;
        endfunction

        function int unsigned pow2_ceil(int unsigned v);
            int unsigned p;
            p = 1;
            while (p < v) p = p << 1;
            return p;
        endfunction

        function int unsigned word_width();
            return fft_reg ? 2 * comp_bits() : comp_bits();
        endfunction

        function int unsigned bytes_per_sample();
            return pow2_ceil((word_width() + 7) / 8);
        endfunction

        function int unsigned start_run();
            return pow2_ceil(word_width() / 8 + 1);
        endfunction

        function longint component(logic [63:0] v, int unsigned n);
            logic [63:0] x;
            x = v & ((64'd1 << n) - 64'd1);
            if (x[n-1]) return longint'(x) - longint'(64'd1 << n);
            return longint'(x);
        endfunction

        // Rounded magnitude, exact in integers: floor root, then round up
        // when the remainder exceeds the root.
        function logic [63:0] magnitude(longint a, longint b);
            logic [63:0] n, r, bit_w, sum;
            n = (a < 0 ? -a : a) * (a < 0 ? -a : a)
                + (b < 0 ? -b : b) * (b < 0 ? -b : b);
            sum = n;
            r = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > n) bit_w = bit_w >> 2;
            while (bit_w != 0) begin
                if (n >= r + bit_w) begin
                    n = n - (r + bit_w);
                    r = (r >> 1) + bit_w;
                end else begin
                    r = r >> 1;
                end
                bit_w = bit_w >> 2;
            end
            if (sum - r * r > r) r = r + 1;
            return r;
        endfunction

        function void push_event(t_event k, logic signed [SAMPLE_W-1:0] v, int unsigned i);
            t_sweep_event e;
            e.kind = k;
            e.value = v;
            e.index = i[INDEX_W-1:0];
            due.push_back(e);
        endfunction

        // Advance the predicted state by one accepted request.
        function void note_byte(logic [7:0] b);
            int unsigned nbytes, nflags, shift, idx;
            longint a;
            logic signed [SAMPLE_W-1:0] v;
            nflags = start_run();
            if (track == SAMPLES) begin
                nbytes = bytes_per_sample();
                shift = (byte_pos < nbytes) ? 8 * (nbytes - 1 - byte_pos) : 0;
                word = word | (64'(b) << shift);
                if (byte_pos + 1 < nbytes) begin
                    byte_pos = (byte_pos + 1) & 7;
                    return;
                end
                byte_pos = 0;
                a = component(word, comp_bits());
                if (fft_reg)
                    v = SAMPLE_W'(magnitude(a, component(word >> comp_bits(), comp_bits())));
                else
                    v = SAMPLE_W'(a);
                word = '0;
                idx = sweep_pos;
                sweep_pos++;
                if (idx + 1 < sample_count()) begin
                    push_event(EV_SAMPLE, v, idx);
                    return;
                end
                held_value = v;
                flag_count = 0;
                track = STOPS;
                return;
            end
            if (track == STOPS) begin
                if (b == STOP_BYTE) begin
                    flag_count++;
                    if (flag_count < nflags) return;
                    push_event(EV_FINAL, held_value, sweep_pos - 1);
                end else begin
                    push_event(EV_ABORT, '0, 0);
                end
                track = HUNT;
                flag_count = 0;
                byte_pos = 0;
                word = '0;
                sweep_pos = 0;
                return;
            end
            if (b == START_BYTE) flag_count++;
            else flag_count = 0;
            if (flag_count >= nflags) begin
                track = SAMPLES;
                flag_count = 0;
                byte_pos = 0;
                word = '0;
                sweep_pos = 0;
            end
        endfunction

        function void check_event(logic [OUT_W-1:0] d);
            t_sweep_event e;
            logic [1:0] k;
            logic signed [SAMPLE_W-1:0] v;
            logic [INDEX_W-1:0] i;
            k = d[OUT_W-1 -: 2];
            v = d[INDEX_W +: SAMPLE_W];
            i = d[INDEX_W-1:0];
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected event: kind %0d value %0d index %0d", k, v, i);
                return;
            end
            e = due.pop_front();
            if (k !== e.kind || v !== e.value || i !== e.index) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Event mismatch: expected kind %0d value %0d index %0d, ",
                              "got kind %0d value %0d index %0d"},
                             e.kind, e.value, e.index, k, v, i);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    rsd_stream_if #(.W(8))     in_if();
    rsd_stream_if #(.W(OUT_W)) out_if();

    radar_sweep_deframer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .in_s        (in_if.sink),
        .out_s       (out_if.source)
    );

    sweep_scoreboard sb;
    logic [7:0] byte_queue[$];
    int unsigned bytes_sent;
    bit hold_request;

    // Clock: 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The run is cut off if it hangs anywhere.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Every accepted request advances the predictor; every accepted result
    // is checked against the oldest pending event.
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) sb.note_byte(in_if.data);
        if (i_rst_n && out_if.valid && out_if.ready) sb.check_event(out_if.data);
    end

    // The receiver stalls on a pattern that changes at random intervals.
    // When asked, it holds off for a long stretch so that the block backs up
    // and stalls its input.
    initial begin
        int unsigned style, left;
        out_if.ready = 1'b0;
        style = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                out_if.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                if (left == 0) begin
                    style = $urandom_range(0, 3);
                    left = $urandom_range(10, 80);
                end
                left--;
                case (style)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 1) == 1);
                    2: out_if.ready <= ($urandom_range(0, 4) == 0);
                    default: out_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic write_reg(t_reg idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every predicted event has come out, then give an fft sample
    // still inside the root unit time to finish before touching registers.
    task automatic wait_idle();
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (2 * MAX_SAMPLE_BITS + 16) @(posedge i_clk);
    endtask

    task automatic configure(int unsigned nbits, int unsigned len, bit fft);
        wait_idle();
        write_reg(REG_SAMPLE_BITS, CFG_W'(nbits));
        write_reg(REG_SWEEP_LENGTH, CFG_W'(len));
        write_reg(REG_FFT_MODE, CFG_W'(fft));
    endtask

    // Sends the queued bytes in bursts of random length with random gaps.
    task automatic send_queue();
        int unsigned burst;
        burst = 0;
        while (byte_queue.size() != 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) == 0) begin
                    @(negedge i_clk);
                    in_if.valid <= 1'b0;
                    repeat ($urandom_range(0, 6)) @(negedge i_clk);
                end
            end
            if (in_if.valid !== 1'b1 || burst != 0) @(negedge i_clk);
            in_if.valid <= 1'b1;
            in_if.data <= byte_queue.pop_front();
            @(posedge i_clk);
            while (!in_if.ready) @(posedge i_clk);
            bytes_sent++;
            burst--;
        end
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    function automatic logic [7:0] fill_byte(int unsigned fill);
        case (fill)
            1: return 8'h00;
            2: return 8'hFF;
            3: return ($urandom_range(0, 1) == 1) ? 8'h80 : 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Queue one framed sweep under the current settings. A bad frame always breaks
    // the stop run, and at random also puts a broken start run before the full one.
    task automatic queue_sweep(int unsigned fill, bit bad);
        int unsigned nflags, nbytes, nsamp, k, cut;
        nflags = sb.start_run();
        nbytes = sb.bytes_per_sample();
        nsamp = sb.sample_count();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) byte_queue.push_back(8'($urandom_range(0, 255)));
        if (bad && $urandom_range(0, 1) == 1 && nflags > 1) begin
            repeat ($urandom_range(1, nflags - 1)) byte_queue.push_back(START_BYTE);
            byte_queue.push_back(8'($urandom_range(0, 254)));
        end
        repeat (nflags) byte_queue.push_back(START_BYTE);
        for (k = 0; k < nsamp * nbytes; k++) byte_queue.push_back(fill_byte(fill));
        cut = bad ? $urandom_range(0, nflags - 1) : nflags;
        repeat (cut) byte_queue.push_back(STOP_BYTE);
        if (cut < nflags) byte_queue.push_back(($urandom_range(0, 1) == 1) ?
                                              8'hFF : 8'($urandom_range(0, 142)));
    endtask

    initial begin
        int unsigned nbits, len, sweeps;
        bit fft;
        sb = new();
        sb.reset_state();
        bytes_sent = 0;
        hold_request = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_SAMPLE_BITS;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: the narrowest plain sample in a single-sample sweep,
        // then an aborted one, component extremes in fft mode and clamped maximum plain settings.
        configure(0, 0, 0);
        byte_queue = '{8'h00, 8'hFF, 8'h02, 8'h8F, 8'hFF, 8'h01, 8'hFF};
        send_queue();
        configure(24, 2, 1);
        queue_sweep(3, 0);
        send_queue();
        configure(31, 131071, 0);
        byte_queue = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                       8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_queue();

        // A shorter length lands on a sweep already past it: the next sample
        // ends the sweep.
        configure(24, 1, 0);
        byte_queue = '{8'h00, 8'h80, 8'h00, 8'h01, 8'h8F, 8'h8F, 8'h8F, 8'h8F};
        send_queue();

        // Random part: settings change between groups of sweeps, most
        // sweeps are well formed with random samples.
        while (bytes_sent < 1150) begin
            if ($urandom_range(0, 4) == 0) nbits = ($urandom_range(0, 1) == 1) ? 24 : 2;
            else nbits = $urandom_range(0, 31);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
            fft = $urandom_range(0, 1);
            configure(nbits, len, fft);
            if (bytes_sent > 400 && bytes_sent < 700) hold_request = 1'b1;
            sweeps = $urandom_range(2, 5);
            repeat (sweeps) queue_sweep(($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0,
                                        $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 8)) byte_queue.push_back(8'($urandom_range(0, 255)));
            send_queue();
        end

        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (2 * MAX_SAMPLE_BITS + 16) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
